// ===== rtl/core/crtc_pkg.sv =====
// crtc_pkg: shared types and constants for the CRT timing controller.
// Holds the transaction structs, bus command codes and register indexes.
// No dependencies.
package crtc_pkg;

  // Default width of the display memory address counters
  localparam int ADDRESS_WIDTH_DEF = 16;

  // Bus and tick command codes carried in each input transaction
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Register file indexes
  localparam logic [3:0] REG_HTOTAL       = 4'd0;
  localparam logic [3:0] REG_HDISP        = 4'd1;
  localparam logic [3:0] REG_HSYNC_POS    = 4'd2;
  localparam logic [3:0] REG_SYNC_WIDTH   = 4'd3;
  localparam logic [3:0] REG_VTOTAL       = 4'd4;
  localparam logic [3:0] REG_VADJUST      = 4'd5;
  localparam logic [3:0] REG_VDISP        = 4'd6;
  localparam logic [3:0] REG_VSYNC_POS    = 4'd7;
  localparam logic [3:0] REG_MAX_SCAN     = 4'd9;
  localparam logic [3:0] REG_CURSOR_START = 4'd10;
  localparam logic [3:0] REG_CURSOR_END   = 4'd11;
  localparam logic [3:0] REG_START_HI     = 4'd12;
  localparam logic [3:0] REG_START_LO     = 4'd13;
  localparam logic [3:0] REG_CURSOR_HI    = 4'd14;
  localparam logic [3:0] REG_CURSOR_LO    = 4'd15;

  // Cursor blink modes held in R10 bits 6..5
  localparam logic [1:0] BLINK_STEADY  = 2'd0;
  localparam logic [1:0] BLINK_HIDDEN  = 2'd1;
  localparam logic [1:0] BLINK_EVERY16 = 2'd2;
  localparam logic [1:0] BLINK_EVERY32 = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] bus_data;
  } item_t;

  // Output transaction
  typedef struct packed {
    logic [7:0]  read_data;
    logic        display_enable;
    logic [15:0] mem_address;
    logic [8:0]  row_address;
    logic        cursor_hit;
    logic        hsync_out;
    logic        vsync_out;
  } result_t;

  // Bus access controls from the timing core to the register file
  typedef struct packed {
    logic       sel_we;
    logic       data_we;
    logic [7:0] data;
  } bus_ctl_t;

  // Register file contents as seen by the timing logic
  typedef struct packed {
    logic [7:0] htotal;
    logic [7:0] hdisp;
    logic [7:0] hsync_pos;
    logic [7:0] sync_width;
    logic [7:0] vtotal;
    logic [7:0] vadjust;
    logic [7:0] vdisp;
    logic [7:0] vsync_pos;
    logic [7:0] max_scan;
    logic [7:0] cursor_start;
    logic [7:0] cursor_end;
    logic [7:0] start_hi;
    logic [7:0] start_lo;
    logic [7:0] cursor_hi;
    logic [7:0] cursor_lo;
  } crtc_regs_t;

endpackage

// ===== rtl/core/crtc_regfile.sv =====
// crtc_regfile: register select latch, sixteen 8-bit registers and read mux.
// Depends on crtc_pkg for the bus control and register view structs.
module crtc_regfile (
  input  logic                  clk,
  input  logic                  rst,
  input  crtc_pkg::bus_ctl_t    bus,
  output crtc_pkg::crtc_regs_t  regs,
  output logic [7:0]            read_data
);

  logic [7:0] reg_file [16];
  logic [4:0] reg_select;

  // Select latch and register writes; selections above R15 drop writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_select <= '0;
      for (int i = 0; i < 16; i++) begin
        reg_file[i] <= '0;
      end
    end else begin
      if (bus.sel_we) begin
        reg_select <= bus.data[4:0];
      end
      if (bus.data_we && !reg_select[4]) begin
        reg_file[reg_select[3:0]] <= bus.data;
      end
    end
  end

  // Only the cursor address reads back; light pen and the rest read zero
  always_comb begin
    if (reg_select == {1'b0, crtc_pkg::REG_CURSOR_HI}) begin
      read_data = reg_file[crtc_pkg::REG_CURSOR_HI];
    end else if (reg_select == {1'b0, crtc_pkg::REG_CURSOR_LO}) begin
      read_data = reg_file[crtc_pkg::REG_CURSOR_LO];
    end else begin
      read_data = '0;
    end
  end

  // Named view of the registers
  assign regs.htotal       = reg_file[crtc_pkg::REG_HTOTAL];
  assign regs.hdisp        = reg_file[crtc_pkg::REG_HDISP];
  assign regs.hsync_pos    = reg_file[crtc_pkg::REG_HSYNC_POS];
  assign regs.sync_width   = reg_file[crtc_pkg::REG_SYNC_WIDTH];
  assign regs.vtotal       = reg_file[crtc_pkg::REG_VTOTAL];
  assign regs.vadjust      = reg_file[crtc_pkg::REG_VADJUST];
  assign regs.vdisp        = reg_file[crtc_pkg::REG_VDISP];
  assign regs.vsync_pos    = reg_file[crtc_pkg::REG_VSYNC_POS];
  assign regs.max_scan     = reg_file[crtc_pkg::REG_MAX_SCAN];
  assign regs.cursor_start = reg_file[crtc_pkg::REG_CURSOR_START];
  assign regs.cursor_end   = reg_file[crtc_pkg::REG_CURSOR_END];
  assign regs.start_hi     = reg_file[crtc_pkg::REG_START_HI];
  assign regs.start_lo     = reg_file[crtc_pkg::REG_START_LO];
  assign regs.cursor_hi    = reg_file[crtc_pkg::REG_CURSOR_HI];
  assign regs.cursor_lo    = reg_file[crtc_pkg::REG_CURSOR_LO];

endmodule

// ===== rtl/core/crt_timing_controller_core.sv =====
// crt_timing_controller_core: top level of the CRT timing controller.
// Depends on crtc_pkg and crtc_regfile.

// Each transaction is a character clock tick or one bus access (select,
// register write, register read) and yields exactly one result. The block
// takes one transaction every clock unless item_stall holds the input
// register while the output register is stalled; a transaction is captured
// in the input register and its result is then written to the output
// register. The whole horizontal, scan line, row, adjust and frame advance
// for one tick is done by the combinational logic between those two registers.
// Only R14/R15 read back; every other selection reads zero, and light pen
// capture is not provided.
module crt_timing_controller_core #(
  parameter int ADDRESS_WIDTH = crtc_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  crtc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output crtc_pkg::result_t result
);

  // Input stage
  logic            s1_valid;
  crtc_pkg::item_t s1_item;
  logic            advance;
  logic            s1_fire;

  // Timing state
  logic [8:0]               char_count, char_count_next;
  logic [4:0]               hsync_count, hsync_count_next;
  logic                     hsync_on, hsync_on_next;
  logic                     hdisp_on, hdisp_on_next;
  logic [8:0]               row_count, row_count_next;
  logic [8:0]               scan_count, scan_count_next;
  logic [7:0]               adjust_count, adjust_count_next;
  logic [4:0]               vsync_count, vsync_count_next;
  logic                     vsync_on, vsync_on_next;
  logic                     vdisp_on, vdisp_on_next;
  logic                     adjust_phase, adjust_phase_next;
  logic [ADDRESS_WIDTH-1:0] current_address, current_address_next;
  logic [ADDRESS_WIDTH-1:0] row_start, row_start_next;
  logic [7:0]               blink_count, blink_count_next;
  logic                     cursor_shown, cursor_shown_next;

  crtc_pkg::result_t    result_next;
  crtc_pkg::bus_ctl_t   bus;
  crtc_pkg::crtc_regs_t regs;
  logic [7:0]           reg_read_data;

  logic [15:0]              start_pair, cursor_pair;
  logic [ADDRESS_WIDTH-1:0] start_addr, cursor_addr;
  logic [4:0]               hsync_len, vsync_len;
  logic [1:0]               cursor_blink_sel;

  // Handshake: the output register frees the input stage
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign s1_fire    = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  // Register file
  assign bus.sel_we  = s1_fire && (s1_item.cmd == crtc_pkg::CMD_SELECT);
  assign bus.data_we = s1_fire && (s1_item.cmd == crtc_pkg::CMD_WRITE);
  assign bus.data    = s1_item.bus_data;

  crtc_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .bus       (bus),
    .regs      (regs),
    .read_data (reg_read_data)
  );

  // Decoded register values
  assign start_pair       = {regs.start_hi, regs.start_lo};
  assign cursor_pair      = {regs.cursor_hi, regs.cursor_lo};
  assign start_addr       = start_pair[ADDRESS_WIDTH-1:0];
  assign cursor_addr      = cursor_pair[ADDRESS_WIDTH-1:0];
  assign hsync_len        = (regs.sync_width[3:0] == 4'd0) ? 5'd16 : {1'b0, regs.sync_width[3:0]};
  assign vsync_len        = (regs.sync_width[7:4] == 4'd0) ? 5'd16 : {1'b0, regs.sync_width[7:4]};
  assign cursor_blink_sel = regs.cursor_start[6:5];

  // Per-transaction work: bus result or one character advance
  always_comb begin
    char_count_next      = char_count;
    hsync_count_next     = hsync_count;
    hsync_on_next        = hsync_on;
    hdisp_on_next        = hdisp_on;
    row_count_next       = row_count;
    scan_count_next      = scan_count;
    adjust_count_next    = adjust_count;
    vsync_count_next     = vsync_count;
    vsync_on_next        = vsync_on;
    vdisp_on_next        = vdisp_on;
    adjust_phase_next    = adjust_phase;
    current_address_next = current_address;
    row_start_next       = row_start;
    blink_count_next     = blink_count;
    cursor_shown_next    = cursor_shown;
    result_next          = '0;

    case (s1_item.cmd)
      crtc_pkg::CMD_READ: begin
        result_next.read_data = reg_read_data;
      end
      crtc_pkg::CMD_TICK: begin
        result_next.mem_address = 16'(current_address);
        result_next.row_address = scan_count;
        if (hdisp_on && vdisp_on) begin
          result_next.display_enable = 1'b1;
          result_next.cursor_hit = cursor_shown && (current_address == cursor_addr) &&
                                   (scan_count >= {4'b0, regs.cursor_start[4:0]}) &&
                                   (scan_count <= {1'b0, regs.cursor_end});
          current_address_next = current_address + 1'b1;
        end

        // Horizontal counters
        char_count_next = char_count + 9'd1;
        if (char_count_next >= {1'b0, regs.hdisp}) begin
          hdisp_on_next = 1'b0;
        end
        if (char_count_next == {1'b0, regs.hsync_pos}) begin
          hsync_on_next    = 1'b1;
          hsync_count_next = '0;
        end
        if (hsync_on_next) begin
          hsync_count_next = hsync_count_next + 5'd1;
          if (hsync_count_next >= hsync_len) begin
            hsync_on_next = 1'b0;
          end
        end

        // End of line: scan line, row, adjust and frame
        if (char_count_next > {1'b0, regs.htotal}) begin
          char_count_next = '0;
          hdisp_on_next   = 1'b1;
          if (adjust_phase) begin
            adjust_count_next = adjust_count + 8'd1;
            if (adjust_count_next >= regs.vadjust) begin
              adjust_phase_next    = 1'b0;
              row_count_next       = '0;
              scan_count_next      = '0;
              vdisp_on_next        = 1'b1;
              current_address_next = start_addr;
              row_start_next       = start_addr;
              case (cursor_blink_sel)
                crtc_pkg::BLINK_STEADY: cursor_shown_next = 1'b1;
                crtc_pkg::BLINK_HIDDEN: cursor_shown_next = 1'b0;
                crtc_pkg::BLINK_EVERY16: begin
                  blink_count_next  = blink_count + 8'd1;
                  cursor_shown_next = !blink_count_next[4];
                end
                default: begin
                  blink_count_next  = blink_count + 8'd1;
                  cursor_shown_next = !blink_count_next[5];
                end
              endcase
            end
          end else begin
            scan_count_next = scan_count + 9'd1;
            if (scan_count_next > {1'b0, regs.max_scan}) begin
              scan_count_next = '0;
              row_count_next  = row_count + 9'd1;
              row_start_next  = current_address_next;
              if (row_count_next >= {1'b0, regs.vdisp}) begin
                vdisp_on_next = 1'b0;
              end
              if (row_count_next == {1'b0, regs.vsync_pos}) begin
                vsync_on_next    = 1'b1;
                vsync_count_next = '0;
              end
              if (row_count_next > {1'b0, regs.vtotal}) begin
                adjust_phase_next = 1'b1;
                adjust_count_next = '0;
                vsync_on_next     = 1'b0;
              end
            end else begin
              current_address_next = row_start;
            end
          end
          if (vsync_on_next) begin
            vsync_count_next = vsync_count_next + 5'd1;
            if (vsync_count_next >= vsync_len) begin
              vsync_on_next = 1'b0;
            end
          end
        end
      end
      default: begin
        // select and register writes are handled by the register file
      end
    endcase

    result_next.hsync_out = hsync_on_next;
    result_next.vsync_out = vsync_on_next;
  end

  // Timing state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= '0;
      hsync_count     <= '0;
      hsync_on        <= 1'b0;
      hdisp_on        <= 1'b0;
      row_count       <= '0;
      scan_count      <= '0;
      adjust_count    <= '0;
      vsync_count     <= '0;
      vsync_on        <= 1'b0;
      vdisp_on        <= 1'b0;
      adjust_phase    <= 1'b0;
      current_address <= '0;
      row_start       <= '0;
      blink_count     <= '0;
      cursor_shown    <= 1'b1;
    end else if (s1_fire) begin
      char_count      <= char_count_next;
      hsync_count     <= hsync_count_next;
      hsync_on        <= hsync_on_next;
      hdisp_on        <= hdisp_on_next;
      row_count       <= row_count_next;
      scan_count      <= scan_count_next;
      adjust_count    <= adjust_count_next;
      vsync_count     <= vsync_count_next;
      vsync_on        <= vsync_on_next;
      vdisp_on        <= vdisp_on_next;
      adjust_phase    <= adjust_phase_next;
      current_address <= current_address_next;
      row_start       <= row_start_next;
      blink_count     <= blink_count_next;
      cursor_shown    <= cursor_shown_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  // A bus transaction reports no display position
  a_bus_no_display: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.cmd != crtc_pkg::CMD_TICK) |=>
      (!result.display_enable && result.mem_address == '0 && result.row_address == '0))
    else $error("bus transaction reported display fields");

  // Read data only comes from a read transaction
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.cmd != crtc_pkg::CMD_READ) |=> (result.read_data == '0))
    else $error("read data on a non-read transaction");

  // Cursor hit only inside the active display area
  a_cursor_in_display: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.cursor_hit) |-> result.display_enable)
    else $error("cursor hit outside display area");

  // Vertical sync is off throughout the adjust lines
  a_adjust_no_vsync: assert property (@(posedge clk) disable iff (rst)
    adjust_phase |-> !vsync_on)
    else $error("vertical sync active during adjust phase");

  // A held input stage keeps its transaction
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("input stage lost a stalled transaction");
`endif

endmodule
